@@ rtl/imh_pkg.sv @@
// Shared constants, codes and types of the indexed min-heap unit.
package imh_pkg;

	// Heap sizing.
	localparam int CAPACITY   = 1024;
	localparam int COST_BITS  = 32;
	localparam int NAME_W     = 10;
	localparam int NAME_SPACE = 1 << NAME_W;
	localparam int ADDR_W     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int SLOT_W     = $clog2(CAPACITY + 1);
	localparam int POS_W      = SLOT_W + 1;

	typedef logic [COST_BITS-1:0] cost_t;
	typedef logic [NAME_W-1:0]    name_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [POS_W-1:0]     pos_t;

	// Request kinds.
	localparam logic [1:0] KIND_INSERT   = 2'd0;
	localparam logic [1:0] KIND_DECREASE = 2'd1;
	localparam logic [1:0] KIND_DELMIN   = 2'd2;
	localparam logic [1:0] KIND_QUERY    = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_DUP       = 3'd3;
	localparam logic [2:0] ST_ABSENT    = 3'd4;
	localparam logic [2:0] ST_NOT_LOWER = 3'd5;

	// Access bundle from the sequencer to the storage.
	typedef struct packed {
		addr_t sn_raddr;
		logic  sn_we;
		addr_t sn_waddr;
		name_t sn_wdata;
		name_t nc_raddr;
		logic  nc_we;
		name_t nc_waddr;
		cost_t nc_wdata;
		name_t ns_raddr;
		logic  ns_we;
		name_t ns_waddr;
		slot_t ns_wdata;
	} mem_req_t;

	// Registered read data from the storage.
	typedef struct packed {
		name_t sn_rdata;
		cost_t nc_rdata;
		slot_t ns_rdata;
	} mem_rsp_t;

endpackage

@@ rtl/imh_in_if.sv @@
// Request channel: valid/ready handshake carrying one heap request item.
interface imh_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [9:0]  elem_name;
	logic [31:0] elem_cost;

	modport source (output valid, kind, elem_name, elem_cost, input ready);
	modport sink (input valid, kind, elem_name, elem_cost, output ready);
endinterface

@@ rtl/imh_out_if.sv @@
// Result channel: valid/ready handshake carrying one heap result item.
interface imh_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [9:0]  best_name;
	logic [31:0] best_cost;
	logic        present;
	logic [10:0] occupancy;

	modport source (output valid, status, best_name, best_cost, present, occupancy,
		input ready);
	modport sink (input valid, status, best_name, best_cost, present, occupancy,
		output ready);
endinterface

@@ rtl/imh_store.sv @@
// Heap storage: slot-to-name, name-to-cost and name-to-slot memories.
module imh_store (
	input  logic             clk,
	input  logic             arst_n,
	input  imh_pkg::mem_req_t mreq,
	output imh_pkg::mem_rsp_t mrsp,
	output logic             clr_done
);
	import imh_pkg::*;

	name_t slot_name_mem [CAPACITY];
	cost_t name_cost_mem [NAME_SPACE];
	slot_t name_slot_mem [NAME_SPACE];

	logic [NAME_W:0] clr_q;
	name_t           sn_rdata_q;
	cost_t           nc_rdata_q;
	slot_t           ns_rdata_q;

	// Clearing pass over the name-to-slot table after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[NAME_W]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign clr_done = clr_q[NAME_W];

	// Slot-to-name memory.
	always_ff @(posedge clk) begin
		if (mreq.sn_we) begin
			slot_name_mem[mreq.sn_waddr] <= mreq.sn_wdata;
		end
		sn_rdata_q <= slot_name_mem[mreq.sn_raddr];
	end

	// Name-to-cost memory.
	always_ff @(posedge clk) begin
		if (mreq.nc_we) begin
			name_cost_mem[mreq.nc_waddr] <= mreq.nc_wdata;
		end
		nc_rdata_q <= name_cost_mem[mreq.nc_raddr];
	end

	// Name-to-slot memory; the clearing pass owns the write port until done.
	always_ff @(posedge clk) begin
		if (!clr_q[NAME_W]) begin
			name_slot_mem[clr_q[NAME_W-1:0]] <= '0;
		end else if (mreq.ns_we) begin
			name_slot_mem[mreq.ns_waddr] <= mreq.ns_wdata;
		end
		ns_rdata_q <= name_slot_mem[mreq.ns_raddr];
	end

	// Registered read data back to the sequencer.
	assign mrsp.sn_rdata = sn_rdata_q;
	assign mrsp.nc_rdata = nc_rdata_q;
	assign mrsp.ns_rdata = ns_rdata_q;

endmodule

@@ rtl/indexed_min_heap_decrease_key_unit.sv @@
// Top level: request sequencer with a shared cost comparator over the heap storage.
// Indexed binary min-heap with decrease-key.
// Requests arrive on req (kind, elem_name, elem_cost); each yields exactly one
// result on rsp (status, best_name, best_cost, present, occupancy).
// After reset the name-to-slot table is cleared one entry a cycle, so req.ready
// stays low until all 1024 entries have been cleared.
// One request is worked on at a time; a shared comparator and single-port
// memory reads set the pace, one read per memory per cycle with registered data.
// A query or a rejected insert or decrease ends after the table lookup; insert
// and decrease then move the element up the heap level by level, and
// delete-min moves the last element down the heap level by level.
// The result sits in an output register; when rsp stalls, the next request
// is still accepted and worked on, and waits at its end until the register
// frees up.
// The heap count and all handshake state return to empty/idle on reset.
module indexed_min_heap_decrease_key_unit (
	input logic     clk,
	input logic     arst_n,
	imh_in_if.sink  req,
	imh_out_if.source rsp
);
	import imh_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_CHK  = 16'h0002,
		S_UP   = 16'h0004,
		S_UPN  = 16'h0008,
		S_UPC  = 16'h0010,
		S_UPF  = 16'h0020,
		S_D1   = 16'h0040,
		S_D2   = 16'h0080,
		S_D3   = 16'h0100,
		S_DL   = 16'h0200,
		S_DA   = 16'h0400,
		S_DB   = 16'h0800,
		S_DC   = 16'h1000,
		S_DD   = 16'h2000,
		S_DF   = 16'h4000,
		S_OUT  = 16'h8000
	} state_t;

	state_t     st_q;
	logic [1:0] kind_q;
	name_t      name_q;
	cost_t      cost_q;
	slot_t      cnt_q;
	slot_t      s_q;
	name_t      pn_q;
	name_t      top_q;
	name_t      last_q;
	cost_t      lc_q;
	pos_t       pos_q;
	name_t      ch_name_q;
	cost_t      ch_cost_q;
	name_t      nb_q;
	logic [2:0] status_q;
	name_t      bname_q;
	cost_t      bcost_q;
	logic       pres_q;

	mem_req_t mreq;
	mem_rsp_t mrsp;
	logic     clr_done;

	cost_t cmp_a;
	cost_t cmp_b;
	logic  cmp_lt;
	slot_t up_slot;
	slot_t pos_half;
	logic  accept;
	logic  out_load;

	imh_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.mreq     (mreq),
		.mrsp     (mrsp),
		.clr_done (clr_done)
	);

	assign accept   = req.valid && req.ready;
	assign up_slot  = s_q >> 1;
	assign pos_half = SLOT_W'(pos_q >> 1);
	assign out_load = (st_q == S_OUT) && (!rsp.valid || rsp.ready);

	// Shared cost comparator, operands chosen by the sequencer state.
	always_comb begin
		cmp_a = cost_q;
		cmp_b = mrsp.nc_rdata;
		unique case (st_q)
			S_DC: begin
				cmp_a = mrsp.nc_rdata;
				cmp_b = ch_cost_q;
			end
			S_DD: begin
				cmp_a = ch_cost_q;
				cmp_b = lc_q;
			end
			default: begin
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;

	// Memory addresses and writes.
	always_comb begin
		mreq = '0;
		unique case (st_q)
			S_IDLE: begin
				mreq.ns_raddr = req.elem_name;
				mreq.nc_raddr = req.elem_name;
				mreq.sn_raddr = '0;
			end
			S_UP: begin
				mreq.sn_raddr = ADDR_W'(up_slot - 1'b1);
			end
			S_UPN: begin
				mreq.nc_raddr = mrsp.sn_rdata;
			end
			S_UPC: begin
				if (cmp_lt) begin
					mreq.sn_we    = 1'b1;
					mreq.sn_waddr = ADDR_W'(s_q - 1'b1);
					mreq.sn_wdata = pn_q;
					mreq.ns_we    = 1'b1;
					mreq.ns_waddr = pn_q;
					mreq.ns_wdata = s_q;
				end
			end
			S_UPF: begin
				mreq.nc_we    = 1'b1;
				mreq.nc_waddr = name_q;
				mreq.nc_wdata = cost_q;
				mreq.sn_we    = 1'b1;
				mreq.sn_waddr = ADDR_W'(s_q - 1'b1);
				mreq.sn_wdata = name_q;
				mreq.ns_we    = 1'b1;
				mreq.ns_waddr = name_q;
				mreq.ns_wdata = s_q;
			end
			S_D1: begin
				mreq.nc_raddr = mrsp.sn_rdata;
				mreq.sn_raddr = ADDR_W'(cnt_q - 1'b1);
			end
			S_D2: begin
				mreq.ns_we    = 1'b1;
				mreq.ns_waddr = top_q;
				mreq.ns_wdata = '0;
				mreq.nc_raddr = mrsp.sn_rdata;
			end
			S_DL: begin
				mreq.sn_raddr = ADDR_W'(pos_q - 1'b1);
			end
			S_DA: begin
				mreq.nc_raddr = mrsp.sn_rdata;
				mreq.sn_raddr = ADDR_W'(pos_q);
			end
			S_DB: begin
				mreq.nc_raddr = mrsp.sn_rdata;
			end
			S_DD: begin
				if (cmp_lt) begin
					mreq.sn_we    = 1'b1;
					mreq.sn_waddr = ADDR_W'(pos_half - 1'b1);
					mreq.sn_wdata = ch_name_q;
					mreq.ns_we    = 1'b1;
					mreq.ns_waddr = ch_name_q;
					mreq.ns_wdata = pos_half;
				end
			end
			S_DF: begin
				mreq.sn_we    = 1'b1;
				mreq.sn_waddr = ADDR_W'(pos_half - 1'b1);
				mreq.sn_wdata = last_q;
				mreq.ns_we    = 1'b1;
				mreq.ns_waddr = last_q;
				mreq.ns_wdata = pos_half;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (st_q == S_IDLE) && clr_done;

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (out_load) begin
				rsp.valid <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						kind_q   <= req.kind;
						name_q   <= req.elem_name;
						cost_q   <= cost_t'(req.elem_cost);
						status_q <= ST_OK;
						bname_q  <= '0;
						bcost_q  <= '0;
						pres_q   <= 1'b0;
						if (req.kind == KIND_DELMIN) begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								st_q     <= S_OUT;
							end else begin
								st_q <= S_D1;
							end
						end else begin
							st_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					st_q <= S_OUT;
					case (kind_q)
						KIND_QUERY: begin
							pres_q <= (mrsp.ns_rdata != '0);
						end
						KIND_INSERT: begin
							if (mrsp.ns_rdata != '0) begin
								status_q <= ST_DUP;
							end else if (cnt_q >= SLOT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + 1'b1;
								s_q   <= cnt_q + 1'b1;
								st_q  <= S_UP;
							end
						end
						default: begin
							if (mrsp.ns_rdata == '0) begin
								status_q <= ST_ABSENT;
							end else if (!cmp_lt) begin
								status_q <= ST_NOT_LOWER;
							end else begin
								s_q  <= mrsp.ns_rdata;
								st_q <= S_UP;
							end
						end
					endcase
				end
				S_UP: begin
					st_q <= (up_slot == '0) ? S_UPF : S_UPN;
				end
				S_UPN: begin
					pn_q <= mrsp.sn_rdata;
					st_q <= S_UPC;
				end
				S_UPC: begin
					// Parent is costlier: it moves down and the hole moves up.
					if (cmp_lt) begin
						s_q  <= up_slot;
						st_q <= S_UP;
					end else begin
						st_q <= S_UPF;
					end
				end
				S_UPF: begin
					st_q <= S_OUT;
				end
				S_D1: begin
					top_q <= mrsp.sn_rdata;
					st_q  <= S_D2;
				end
				S_D2: begin
					bname_q <= top_q;
					bcost_q <= mrsp.nc_rdata;
					last_q  <= mrsp.sn_rdata;
					cnt_q   <= cnt_q - 1'b1;
					st_q    <= (cnt_q == SLOT_W'(1)) ? S_OUT : S_D3;
				end
				S_D3: begin
					lc_q  <= mrsp.nc_rdata;
					pos_q <= POS_W'(2);
					st_q  <= S_DL;
				end
				S_DL: begin
					st_q <= (pos_q > POS_W'(cnt_q)) ? S_DF : S_DA;
				end
				S_DA: begin
					ch_name_q <= mrsp.sn_rdata;
					st_q      <= S_DB;
				end
				S_DB: begin
					ch_cost_q <= mrsp.nc_rdata;
					nb_q      <= mrsp.sn_rdata;
					st_q      <= (pos_q < POS_W'(cnt_q)) ? S_DC : S_DD;
				end
				S_DC: begin
					// Right child wins only when strictly cheaper.
					if (cmp_lt) begin
						ch_name_q <= nb_q;
						ch_cost_q <= mrsp.nc_rdata;
						pos_q     <= pos_q + 1'b1;
					end
					st_q <= S_DD;
				end
				S_DD: begin
					if (cmp_lt) begin
						pos_q <= pos_q << 1;
						st_q  <= S_DL;
					end else begin
						st_q <= S_DF;
					end
				end
				S_DF: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						rsp.status    <= status_q;
						rsp.best_name <= bname_q;
						rsp.best_cost <= 32'(bcost_q);
						rsp.present   <= pres_q;
						rsp.occupancy <= 11'(cnt_q);
						st_q          <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOT_W'(CAPACITY))
		else $error("heap count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while busy");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !req.ready)
		else $error("ready during clearing pass");

	a_result_ok_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && status_q == ST_EMPTY) |-> cnt_q == '0)
		else $error("empty status with nonzero count");
`endif

endmodule
